@@ rtl/m3inv_pkg.sv @@
// Package for the 3x3 matrix inverse: widths, status codes, shared types.
// Used by all rtl modules; depends on nothing.
`default_nettype none
package m3inv_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int ProdWidth = 2 * DataWidth;       // one product of two entries
    localparam int CofWidth  = 2 * DataWidth + 1;   // 2x2 cofactor
    localparam int DetWidth  = 3 * DataWidth + 3;   // determinant
    localparam int MagWidth  = DetWidth - 1;        // magnitude of determinant
    localparam int NumWidth  = CofWidth - 1 + 2 * FracBits; // shifted adjugate magnitude
    localparam int QuoWidth  = NumWidth;            // quotient bits
    localparam int Lanes     = 9;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusSingular = 2'd1;
    localparam logic [1:0] StatusSat      = 2'd2;

    typedef logic signed [DataWidth-1:0] data_t;
    typedef logic signed [CofWidth-1:0]  cof_t;
    typedef logic [NumWidth-1:0]         num_t;
    typedef logic [MagWidth-1:0]         mag_t;

    // per-lane control carried beside the divider datapath
    typedef struct packed {
        logic valid;
        logic neg;
        logic singular;
    } lane_ctl_t;
endpackage
`default_nettype wire

@@ rtl/m3inv_cof.sv @@
// One adjugate lane: a signed 2x2 cofactor p*q - r*s, optionally negated.
// Depends on m3inv_pkg. Two registered stages.
`default_nettype none
module m3inv_cof
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic               negate,
    input  wire m3inv_pkg::data_t   p,
    input  wire m3inv_pkg::data_t   q,
    input  wire m3inv_pkg::data_t   r,
    input  wire m3inv_pkg::data_t   s,
    output m3inv_pkg::cof_t         cof
);
    logic signed [m3inv_pkg::ProdWidth-1:0] pq_reg, rs_reg;
    logic neg_reg;
    m3inv_pkg::cof_t cof_reg;

    // products, then difference
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pq_reg  <= p * q;
            rs_reg  <= r * s;
            neg_reg <= negate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg)
                cof_reg <= m3inv_pkg::CofWidth'(rs_reg) - m3inv_pkg::CofWidth'(pq_reg);
            else
                cof_reg <= m3inv_pkg::CofWidth'(pq_reg) - m3inv_pkg::CofWidth'(rs_reg);
        end
    end

    assign cof = cof_reg;
endmodule
`default_nettype wire

@@ rtl/m3inv_div.sv @@
// Pipelined restoring divider lane: one quotient bit per stage, then saturation.
// Depends on m3inv_pkg. All stages advance only under enable.
`default_nettype none
module m3inv_div
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire m3inv_pkg::lane_ctl_t ctl_in,
    input  wire m3inv_pkg::num_t      num,
    input  wire m3inv_pkg::mag_t      mag,
    output m3inv_pkg::lane_ctl_t      ctl_out,
    output m3inv_pkg::data_t          res,
    output logic                      sat
);
    localparam int N = m3inv_pkg::QuoWidth;
    localparam int RW = m3inv_pkg::MagWidth + 1;

    m3inv_pkg::lane_ctl_t ctl_reg [N];
    logic [RW-1:0]        rem_reg [N];
    m3inv_pkg::num_t      n_reg   [N];   // numerator, quotient bits shift in at bottom
    m3inv_pkg::mag_t      d_reg   [N];
    m3inv_pkg::lane_ctl_t octl_reg;
    m3inv_pkg::data_t     res_reg;
    logic                 sat_reg;

    // stage 0 takes the top numerator bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                ctl_reg[i] <= '0;
            octl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < N; i++)
                ctl_reg[i] <= ctl_reg[i-1];
            octl_reg <= ctl_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [RW-1:0] t;
        if (en)
        begin
            t = {{(RW-1){1'b0}}, num[N-1]};
            if (t >= {1'b0, mag})
            begin
                rem_reg[0] <= t - {1'b0, mag};
                n_reg[0]   <= {num[N-2:0], 1'b1};
            end
            else
            begin
                rem_reg[0] <= t;
                n_reg[0]   <= {num[N-2:0], 1'b0};
            end
            d_reg[0] <= mag;
            for (int i = 1; i < N; i++)
            begin
                t = {rem_reg[i-1][RW-2:0], n_reg[i-1][N-1]};
                if (t >= {1'b0, d_reg[i-1]})
                begin
                    rem_reg[i] <= t - {1'b0, d_reg[i-1]};
                    n_reg[i]   <= {n_reg[i-1][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= t;
                    n_reg[i]   <= {n_reg[i-1][N-2:0], 1'b0};
                end
                d_reg[i] <= d_reg[i-1];
            end
        end
    end

    // sign, saturation, singular clear
    always_ff @(posedge clk)
    begin
        logic [N-1:0] qv;
        logic neg;
        logic big;
        if (en)
        begin
            qv  = n_reg[N-1];
            neg = ctl_reg[N-1].neg && (qv != '0);
            if (ctl_reg[N-1].singular)
            begin
                res_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (!neg)
            begin
                big = (qv[N-1:m3inv_pkg::DataWidth-1] != '0);
                res_reg <= big ? {1'b0, {(m3inv_pkg::DataWidth-1){1'b1}}}
                               : m3inv_pkg::DataWidth'(qv);
                sat_reg <= big;
            end
            else
            begin
                big = (qv[N-1:m3inv_pkg::DataWidth-1] != '0) &&
                      (qv != {{(N-m3inv_pkg::DataWidth){1'b0}}, 1'b1,
                              {(m3inv_pkg::DataWidth-1){1'b0}}});
                res_reg <= big ? {1'b1, {(m3inv_pkg::DataWidth-1){1'b0}}}
                               : m3inv_pkg::DataWidth'(~qv + 1'b1);
                sat_reg <= big;
            end
        end
    end

    assign ctl_out = octl_reg;
    assign res     = res_reg;
    assign sat     = sat_reg;
endmodule
`default_nettype wire

@@ rtl/matrix_3x3_inverse.sv @@
// 3x3 matrix inverse by the adjugate, signed Q16.16.
// Input channel (in_valid/in_ready) carries m00..m22; output channel
// (out_valid/out_ready) carries r00..r22 and status (0 ok, 1 singular,
// 2 saturated). One matrix can enter each cycle while in_ready is high.
// Pipeline: 2 cofactor stages, 2 determinant stages (multiply, sum),
// 1 magnitude stage, QuoWidth divider stages (one quotient bit each,
// 96 for the default widths) and 1 saturation stage, then the output
// register. Nine divider lanes run side by side and a merge
// stage folds their saturation flags into the status.
// The whole pipeline advances only when its last stage is free; when the
// receiver stalls, the output holds and the pipe freezes, so in_ready
// falls. Reset clears all valid bits; payload registers are not reset.
// Dependencies: m3inv_pkg, m3inv_cof, m3inv_div.
`default_nettype none
module matrix_3x3_inverse
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire m3inv_pkg::data_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output m3inv_pkg::data_t      r00, r01, r02, r10, r11, r12, r20, r21, r22,
    output logic [1:0]            status
);
    localparam int DW = m3inv_pkg::DetWidth;
    localparam int L  = m3inv_pkg::Lanes;

    logic en;
    m3inv_pkg::data_t a [L];
    m3inv_pkg::cof_t  adj [L];
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    m3inv_pkg::data_t a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic signed [m3inv_pkg::ProdWidth:0] ph0_reg, ph1_reg, ph2_reg;
    logic signed [m3inv_pkg::ProdWidth:0] pl0_reg, pl1_reg, pl2_reg;
    m3inv_pkg::cof_t  adj3_reg [L];
    m3inv_pkg::cof_t  adj4_reg [L];
    logic signed [DW-1:0] det_reg;
    m3inv_pkg::lane_ctl_t lctl [L];
    m3inv_pkg::num_t  lnum [L];
    m3inv_pkg::mag_t  mag_reg;
    m3inv_pkg::cof_t  adj5_reg [L];
    logic             dneg_reg, sing_reg;
    m3inv_pkg::lane_ctl_t octl [L];
    m3inv_pkg::data_t lres [L];
    logic [L-1:0]     lsat;
    logic             ov_reg;
    m3inv_pkg::data_t ores_reg [L];
    logic [1:0]       st_reg;

    assign a[0] = m00; assign a[1] = m01; assign a[2] = m02;
    assign a[3] = m10; assign a[4] = m11; assign a[5] = m12;
    assign a[6] = m20; assign a[7] = m21; assign a[8] = m22;

    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    // adjugate lanes
    m3inv_cof u_c0 (.clk, .en, .negate(1'b0), .p(a[4]), .q(a[8]), .r(a[7]), .s(a[5]), .cof(adj[0]));
    m3inv_cof u_c1 (.clk, .en, .negate(1'b1), .p(a[1]), .q(a[8]), .r(a[7]), .s(a[2]), .cof(adj[1]));
    m3inv_cof u_c2 (.clk, .en, .negate(1'b0), .p(a[1]), .q(a[5]), .r(a[4]), .s(a[2]), .cof(adj[2]));
    m3inv_cof u_c3 (.clk, .en, .negate(1'b1), .p(a[3]), .q(a[8]), .r(a[6]), .s(a[5]), .cof(adj[3]));
    m3inv_cof u_c4 (.clk, .en, .negate(1'b0), .p(a[0]), .q(a[8]), .r(a[6]), .s(a[2]), .cof(adj[4]));
    m3inv_cof u_c5 (.clk, .en, .negate(1'b1), .p(a[0]), .q(a[5]), .r(a[3]), .s(a[2]), .cof(adj[5]));
    m3inv_cof u_c6 (.clk, .en, .negate(1'b0), .p(a[3]), .q(a[7]), .r(a[6]), .s(a[4]), .cof(adj[6]));
    m3inv_cof u_c7 (.clk, .en, .negate(1'b1), .p(a[0]), .q(a[7]), .r(a[6]), .s(a[1]), .cof(adj[7]));
    m3inv_cof u_c8 (.clk, .en, .negate(1'b0), .p(a[0]), .q(a[4]), .r(a[3]), .s(a[1]), .cof(adj[8]));

    // valid chain for the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg;
        end
    end

    // first-row delay to line up with the cofactors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= m00; a1_reg <= m01; a2_reg <= m02;
            b0_reg <= a0_reg; b1_reg <= a1_reg; b2_reg <= a2_reg;
        end
    end

    // determinant: row-0 products (cofactor is 65 bits, split multiply)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph0_reg  <= b0_reg * $signed(adj[0][m3inv_pkg::CofWidth-1:m3inv_pkg::DataWidth]);
            ph1_reg  <= b1_reg * $signed(adj[3][m3inv_pkg::CofWidth-1:m3inv_pkg::DataWidth]);
            ph2_reg  <= b2_reg * $signed(adj[6][m3inv_pkg::CofWidth-1:m3inv_pkg::DataWidth]);
            pl0_reg  <= b0_reg * $signed({1'b0, adj[0][m3inv_pkg::DataWidth-1:0]});
            pl1_reg  <= b1_reg * $signed({1'b0, adj[3][m3inv_pkg::DataWidth-1:0]});
            pl2_reg  <= b2_reg * $signed({1'b0, adj[6][m3inv_pkg::DataWidth-1:0]});
            adj3_reg <= adj;
        end
    end

    // upper and lower partial sums, then recombine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg  <= ((DW'(ph0_reg) + DW'(ph1_reg) + DW'(ph2_reg)) <<< m3inv_pkg::DataWidth)
                      + (DW'(pl0_reg) + DW'(pl1_reg) + DW'(pl2_reg));
            adj4_reg <= adj3_reg;
        end
    end

    // magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= det_reg[DW-1] ? m3inv_pkg::MagWidth'(-det_reg)
                                      : m3inv_pkg::MagWidth'(det_reg);
            dneg_reg <= det_reg[DW-1];
            sing_reg <= (det_reg == '0);
            adj5_reg <= adj4_reg;
        end
    end

    // divider lanes
    for (genvar g = 0; g < L; g++)
    begin : g_lane
        logic [m3inv_pkg::CofWidth-1:0] am;
        assign am = adj5_reg[g][m3inv_pkg::CofWidth-1] ? -adj5_reg[g] : adj5_reg[g];
        assign lnum[g] = {am[m3inv_pkg::CofWidth-2:0], {(2*m3inv_pkg::FracBits){1'b0}}};
        assign lctl[g] = '{valid: v5_reg,
                           neg: adj5_reg[g][m3inv_pkg::CofWidth-1] ^ dneg_reg,
                           singular: sing_reg};
        m3inv_div u_div (.clk, .rst_n, .en, .ctl_in(lctl[g]), .num(lnum[g]),
                         .mag(sing_reg ? {{(m3inv_pkg::MagWidth-1){1'b0}}, 1'b1} : mag_reg),
                         .ctl_out(octl[g]), .res(lres[g]), .sat(lsat[g]));
    end

    // merge stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= octl[0].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ores_reg <= lres;
            if (octl[0].singular)
                st_reg <= m3inv_pkg::StatusSingular;
            else if (lsat != '0)
                st_reg <= m3inv_pkg::StatusSat;
            else
                st_reg <= m3inv_pkg::StatusOk;
        end
    end

    assign out_valid = ov_reg;
    assign r00 = ores_reg[0]; assign r01 = ores_reg[1]; assign r02 = ores_reg[2];
    assign r10 = ores_reg[3]; assign r11 = ores_reg[4]; assign r12 = ores_reg[5];
    assign r20 = ores_reg[6]; assign r21 = ores_reg[7]; assign r22 = ores_reg[8];
    assign status = st_reg;

    // lanes stay in step
    a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
        octl[0].valid == octl[8].valid)
        else $error("divider lanes out of step");
    // singular result is zero on the diagonal
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == m3inv_pkg::StatusSingular |-> r00 == '0 && r11 == '0 && r22 == '0)
        else $error("singular result not cleared");
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(r00))
        else $error("result changed under stall");
endmodule
`default_nettype wire

@@ tb/sv/tb_matrix_3x3_inverse.sv @@
// Testbench for matrix_3x3_inverse: streams 3x3 Q16.16 matrices and checks each inverse
// and status against an exact wide-integer adjugate predictor.
// Depends on m3inv_pkg and the matrix_3x3_inverse RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix_3x3_inverse;
    localparam int RANDOM_MATS = 800;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;

    typedef logic signed [31:0] ent_t;
    typedef logic signed [255:0] wide_t;

    typedef struct {
        ent_t e [9];
    } mat_t;

    typedef struct {
        ent_t e [9];
        logic [1:0] st;
    } inv_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    m3inv_pkg::data_t mi [9];
    m3inv_pkg::data_t ro [9];
    logic [1:0] status;

    mat_t pending_mats[$];
    inv_t expected_invs[$];
    int mismatches = 0;
    int results_seen = 0;
    int accepted_mats = 0;
    int idle_cycles = 0;
    int send_gap;
    int recv_gap;
    int hold_off;
    bit hold_done;
    bit timed_out;
    int singular_seen = 0;
    int sat_seen = 0;

    matrix_3x3_inverse dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m00(mi[0]), .m01(mi[1]), .m02(mi[2]),
        .m10(mi[3]), .m11(mi[4]), .m12(mi[5]),
        .m20(mi[6]), .m21(mi[7]), .m22(mi[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .r00(ro[0]), .r01(ro[1]), .r02(ro[2]),
        .r10(ro[3]), .r11(ro[4]), .r12(ro[5]),
        .r20(ro[6]), .r21(ro[7]), .r22(ro[8]),
        .status(status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // 2x2 cofactor p*q - r*s, exact
    function automatic wide_t cofactor(ent_t p, ent_t q, ent_t r, ent_t s);
        wide_t wp, wq, wr, ws;
        wp = p; wq = q; wr = r; ws = s;
        return wp * wq - wr * ws;
    endfunction

    // inverse by adjugate / determinant, truncating, saturating
    function automatic inv_t predict_inverse(mat_t m);
        inv_t res;
        wide_t adj [9];
        wide_t det, num, mag, quo;
        wide_t hi_lim, lo_mag;
        logic neg;
        logic sat;
        adj[0] = cofactor(m.e[4], m.e[8], m.e[7], m.e[5]);
        adj[1] = -cofactor(m.e[1], m.e[8], m.e[7], m.e[2]);
        adj[2] = cofactor(m.e[1], m.e[5], m.e[4], m.e[2]);
        adj[3] = -cofactor(m.e[3], m.e[8], m.e[6], m.e[5]);
        adj[4] = cofactor(m.e[0], m.e[8], m.e[6], m.e[2]);
        adj[5] = -cofactor(m.e[0], m.e[5], m.e[3], m.e[2]);
        adj[6] = cofactor(m.e[3], m.e[7], m.e[6], m.e[4]);
        adj[7] = -cofactor(m.e[0], m.e[7], m.e[6], m.e[1]);
        adj[8] = cofactor(m.e[0], m.e[4], m.e[3], m.e[1]);
        det = wide_t'(m.e[0]) * adj[0] + wide_t'(m.e[1]) * adj[3]
            + wide_t'(m.e[2]) * adj[6];
        sat = 1'b0;
        if (det == 0)
        begin
            foreach (res.e[i]) res.e[i] = '0;
            res.st = m3inv_pkg::StatusSingular;
            return res;
        end
        mag = (det < 0) ? -det : det;
        hi_lim = (wide_t'(1) <<< 31) - 1;
        lo_mag = wide_t'(1) <<< 31;
        for (int i = 0; i < 9; i++)
        begin
            neg = (adj[i] < 0) != (det < 0);
            num = ((adj[i] < 0) ? -adj[i] : adj[i]) <<< (2 * m3inv_pkg::FracBits);
            quo = num / mag;
            if (quo == 0) neg = 1'b0;
            if (!neg)
            begin
                if (quo > hi_lim) begin quo = hi_lim; sat = 1'b1; end
                res.e[i] = quo[31:0];
            end
            else
            begin
                if (quo > lo_mag) begin quo = lo_mag; sat = 1'b1; end
                res.e[i] = -quo[31:0];
            end
        end
        res.st = sat ? m3inv_pkg::StatusSat : m3inv_pkg::StatusOk;
        return res;
    endfunction

    function automatic ent_t rand_entry(int kind);
        case (kind)
            0: return ent_t'($urandom);
            1: return ent_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return ent_t'($urandom_range(0, 255)) - 128;
            3: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return ent_t'($urandom_range(0, 8)) * 32'sh0001_0000 - 32'sh0004_0000;
        endcase
    endfunction

    task automatic queue_mat(ent_t a0, ent_t a1, ent_t a2, ent_t a3, ent_t a4,
                             ent_t a5, ent_t a6, ent_t a7, ent_t a8);
        mat_t m;
        m.e = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        pending_mats.push_back(m);
    endtask

    // stimulus: directed corners, then random matrices
    initial
    begin
        mat_t m;
        int kind;
        int row;
        ent_t one;
        one = 32'sh0001_0000;
        // identity, scaled identity, zero, singular rows
        queue_mat(one, 0, 0, 0, one, 0, 0, 0, one);
        queue_mat(2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2);
        queue_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_mat(one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one, 7, 8, 9);
        queue_mat(one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one);
        // tiny determinant: saturates
        queue_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
        queue_mat(-1, 0, 0, 0, 1, 0, 0, 0, -1);
        // extremes of the entries
        queue_mat(32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff);
        queue_mat(32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000);
        queue_mat(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh7fff_ffff);
        queue_mat(-1, -1, 0, 0, -1, -1, -1, 0, -1);
        queue_mat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000);
        // permutation with negatives (exact inverse), then an upper-triangular matrix
        queue_mat(0, one, 0, 0, 0, -one, one, 0, 0);
        queue_mat(3 * one, one, 0, 0, one, 0, 0, 0, one);
        // random matrices of mixed magnitude; some forced singular
        for (int n = 0; n < RANDOM_MATS; n++)
        begin
            kind = $urandom_range(0, 4);
            foreach (m.e[i])
                m.e[i] = rand_entry(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : kind);
            if ($urandom_range(0, 9) == 0)
            begin
                // duplicate a row for a zero determinant
                row = $urandom_range(0, 2);
                for (int c = 0; c < 3; c++) m.e[((row + 1) % 3) * 3 + c] = m.e[row * 3 + c];
            end
            pending_mats.push_back(m);
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        mat_t m;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            foreach (mi[i]) mi[i] <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_invs.push_back(predict_inverse(pending_mats.pop_front()));
                accepted_mats <= accepted_mats + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_mats.size() > 0)
                begin
                    m = pending_mats[0];
                    in_valid <= 1'b1;
                    foreach (mi[i]) mi[i] <= m.e[i];
                    if ($urandom_range(0, 3) == 0)
                        send_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(1, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver with one long hold-off to fill the pipe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            hold_off <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_mats >= 200)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off + 1;
            if (hold_off >= 400) hold_done <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                recv_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        inv_t want;
        bit bad;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_invs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end
            else
            begin
                want = expected_invs.pop_front();
                bad = (status !== want.st);
                foreach (ro[i]) if (ro[i] !== want.e[i]) bad = 1'b1;
                if (want.st == m3inv_pkg::StatusSingular) singular_seen++;
                if (want.st == m3inv_pkg::StatusSat) sat_seen++;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at result %0d: status exp %0d got %0d",
                                 results_seen, want.st, status);
                        foreach (ro[i])
                            if (ro[i] !== want.e[i])
                                $display("  entry %0d exp %h got %h", i, want.e[i], ro[i]);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reset, end of run
    initial
    begin
        rst_n = 1'b0;
        timed_out = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (rst_n);
        while ((pending_mats.size() > 0 || expected_invs.size() > 0) && !timed_out)
        begin
            @(posedge clk);
            if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
        end
        if (timed_out)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            $display("%0d matrices inverted, %0d singular, %0d saturated; %0d mismatches",
                     results_seen, singular_seen, sat_seen, mismatches);
            if (mismatches == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
`default_nettype wire
